### hdl/mlo_pkg.sv
// mouse-look orientation package: constants, command and status types, tables, rounding
`default_nettype none
package mlo_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int STEP_W = 4;
  localparam int MOD_STEPS = 2;

  localparam logic [STEP_W-1:0] LAST_ITER = STEP_W'(CORDIC_ITERS - 1);
  localparam logic [STEP_W-1:0] FIRST_MOD = STEP_W'(MOD_STEPS - 1);

  localparam logic [24:0] YAW_HALF_U = 25'd11796480;
  localparam logic [24:0] YAW_FULL_U = 25'd23592960;
  localparam logic [35:0] MOD_BIAS = 36'd6039797760;

  // a full turn is 45 * 2^19, reciprocal is ceil(2^21 / 45)
  localparam logic [15:0] TURN_DIV = 16'd45;
  localparam logic [15:0] RECIP_45 = 16'd46604;

  localparam logic signed [26:0] Z_QUARTER = 27'sd5898240;
  localparam logic signed [26:0] Z_QUARTER_N = -27'sd5898240;
  localparam logic signed [26:0] Z_HALF = 27'sd11796480;
  localparam logic signed [26:0] Z_FULL = 27'sd23592960;

  localparam logic signed [39:0] PITCH_MAX = 40'sd5832704;
  localparam logic signed [39:0] PITCH_MIN = -40'sd5832704;
  localparam logic signed [23:0] PITCH_MAX24 = 24'sd5832704;
  localparam logic signed [23:0] PITCH_MIN24 = -24'sd5832704;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [15:0] SENS_RESET = 16'd6554;
  localparam logic [1:0] REG_SENS = 2'd0;

  localparam logic [1:0] MUL_DX = 2'd0;
  localparam logic [1:0] MUL_DY = 2'd1;
  localparam logic [1:0] MUL_C = 2'd2;
  localparam logic [1:0] MUL_S = 2'd3;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              mod_init;
    logic              mod_step;
    logic              mod_last;
    logic              pitch_we;
    logic              prep;
    logic              rot;
    logic              cap_y;
    logic              cap_x;
    logic              cap_z;
    logic              done;
    logic [STEP_W-1:0] step;
  } mlo_cmd_t;

  typedef struct packed {
    logic en;
  } mlo_stat_t;

  // arctangent of 2^-i in Q.16 degrees
  function automatic logic signed [23:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [23:0] a;
    case (i)
      4'd0:    a = 24'sd2949120;
      4'd1:    a = 24'sd1740967;
      4'd2:    a = 24'sd919879;
      4'd3:    a = 24'sd466945;
      4'd4:    a = 24'sd234379;
      4'd5:    a = 24'sd117304;
      4'd6:    a = 24'sd58666;
      4'd7:    a = 24'sd29335;
      4'd8:    a = 24'sd14668;
      4'd9:    a = 24'sd7334;
      4'd10:   a = 24'sd3667;
      4'd11:   a = 24'sd1833;
      4'd12:   a = 24'sd917;
      4'd13:   a = 24'sd458;
      4'd14:   a = 24'sd229;
      default: a = 24'sd115;
    endcase
    return a;
  endfunction

  // Q4.60 product to Q1.15, round half up, saturate
  function automatic logic signed [15:0] rnd_sat45(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [18:0] r;
    logic signed [15:0] o;
    t = p + 64'sd17592186044416;
    r = t[63:45];
    if (r > 19'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -19'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

  // Q2.30 to Q1.15, round half up, saturate
  function automatic logic signed [15:0] rnd_sat15(input logic signed [31:0] s);
    logic signed [32:0] t;
    logic signed [17:0] r;
    logic signed [15:0] o;
    t = {s[31], s} + 33'sd16384;
    r = t[32:15];
    if (r > 18'sd32767) begin
      o = 16'sh7fff;
    end else if (r < -18'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = r[15:0];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### hdl/mlo_ctrl.sv
// mouse-look orientation controller: sequences update, yaw reduction, cordic and products
`default_nettype none
module mlo_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_mode,
  input  wire logic              out_free,
  input  wire mlo_pkg::mlo_stat_t stat,
  output mlo_pkg::mlo_cmd_t      cmd,
  output logic                   busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MULX = 4'd1;
  localparam logic [3:0] S_MULY = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_ROT  = 4'd5;
  localparam logic [3:0] S_MULC = 4'd6;
  localparam logic [3:0] S_MULS = 4'd7;
  localparam logic [3:0] S_CAPZ = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]                  state_r, state_nxt;
  logic [mlo_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.step = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = (!in_mode && stat.en) ? S_MULX : S_PREP;
        end
      end
      S_MULX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = mlo_pkg::MUL_DX;
        state_nxt = S_MULY;
      end
      S_MULY: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = mlo_pkg::MUL_DY;
        cmd.mod_init = 1'b1;
        cnt_nxt = mlo_pkg::FIRST_MOD;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        cmd.pitch_we = (cnt_r == mlo_pkg::FIRST_MOD);
        if (cnt_r == '0) begin
          cmd.mod_last = 1'b1;
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot = 1'b1;
        if (cnt_r == mlo_pkg::LAST_ITER) begin
          state_nxt = S_MULC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MULC: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = mlo_pkg::MUL_C;
        cmd.cap_y = 1'b1;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = mlo_pkg::MUL_S;
        cmd.cap_x = 1'b1;
        state_nxt = S_CAPZ;
      end
      S_CAPZ: begin
        cmd.cap_z = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/mlo_dpath.sv
// mouse-look orientation datapath: angle state, shared multiplier, yaw remainder, two cordic lanes
`default_nettype none
module mlo_dpath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlo_pkg::mlo_cmd_t  cmd,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_cursor_x,
  input  wire logic signed [15:0] in_cursor_y,
  input  wire logic [15:0]        sens,
  output mlo_pkg::mlo_stat_t      stat,
  output logic signed [15:0]      res_x,
  output logic signed [15:0]      res_y,
  output logic signed [15:0]      res_z,
  output logic                    res_on
);

  logic               en_r, first_r;
  logic signed [15:0] prev_x_r, prev_y_r;
  logic signed [23:0] pitch_r;
  logic [24:0]        yaw_r;
  logic signed [16:0] dx_r, dy_r;
  logic signed [63:0] prod_r;
  logic [34:0]        mod_r;
  logic [9:0]         quo_r;
  logic signed [31:0] xa_r, ya_r, xb_r, yb_r;
  logic signed [26:0] za_r, zb_r;
  logic               nega_r, negb_r;
  logic signed [15:0] rx_r, ry_r, rz_r;

  logic signed [15:0] base_x, base_y;
  logic signed [31:0] ma, mb;
  logic signed [31:0] cyaw, syaw, cpitch, spitch;
  logic [35:0]        mod_sum;
  logic [30:0]        quo_mul;
  logic [15:0]        quo_x45, rem_w;
  logic signed [39:0] pitch_sum, pitch_cl;
  logic signed [26:0] yaw_s, pitch_s, za_in, zb_in;
  logic               nega_in, negb_in;
  logic signed [26:0] at;
  logic signed [31:0] xas, yas, xbs, ybs;

  assign stat.en = en_r;
  assign res_x = rx_r;
  assign res_y = ry_r;
  assign res_z = rz_r;
  assign res_on = en_r;

  assign base_x = first_r ? in_cursor_x : prev_x_r;
  assign base_y = first_r ? in_cursor_y : prev_y_r;

  assign cyaw = nega_r ? -xa_r : xa_r;
  assign syaw = nega_r ? -ya_r : ya_r;
  assign cpitch = negb_r ? -xb_r : xb_r;
  assign spitch = negb_r ? -yb_r : yb_r;

  always_comb begin
    case (cmd.mul_sel)
      mlo_pkg::MUL_DX: begin
        ma = {{15{dx_r[16]}}, dx_r};
        mb = {16'b0, sens};
      end
      mlo_pkg::MUL_DY: begin
        ma = {{15{dy_r[16]}}, dy_r};
        mb = {16'b0, sens};
      end
      mlo_pkg::MUL_C: begin
        ma = cyaw;
        mb = cpitch;
      end
      default: begin
        ma = syaw;
        mb = cpitch;
      end
    endcase
  end

  // yaw remainder: biased sum made positive, upper bits reduced by 45 via reciprocal
  assign mod_sum = {11'b0, yaw_r} + prod_r[35:0] + mlo_pkg::MOD_BIAS;
  assign quo_mul = {16'b0, mod_r[33:19]} * {15'b0, mlo_pkg::RECIP_45};
  assign quo_x45 = {6'b0, quo_r} * mlo_pkg::TURN_DIV;
  assign rem_w = {1'b0, mod_r[33:19]} - quo_x45;

  always_comb begin
    pitch_sum = {{16{pitch_r[23]}}, pitch_r} - $signed(prod_r[39:0]);
    if (pitch_sum > mlo_pkg::PITCH_MAX) begin
      pitch_cl = mlo_pkg::PITCH_MAX;
    end else if (pitch_sum < mlo_pkg::PITCH_MIN) begin
      pitch_cl = mlo_pkg::PITCH_MIN;
    end else begin
      pitch_cl = pitch_sum;
    end
  end

  // fold both angles into the cordic range
  always_comb begin
    if (yaw_r >= mlo_pkg::YAW_HALF_U) begin
      yaw_s = $signed({2'b0, yaw_r}) - mlo_pkg::Z_FULL;
    end else begin
      yaw_s = $signed({2'b0, yaw_r});
    end
    pitch_s = {{3{pitch_r[23]}}, pitch_r};
    nega_in = 1'b0;
    negb_in = 1'b0;
    if (yaw_s > mlo_pkg::Z_QUARTER) begin
      za_in = yaw_s - mlo_pkg::Z_HALF;
      nega_in = 1'b1;
    end else if (yaw_s < mlo_pkg::Z_QUARTER_N) begin
      za_in = yaw_s + mlo_pkg::Z_HALF;
      nega_in = 1'b1;
    end else begin
      za_in = yaw_s;
    end
    if (pitch_s > mlo_pkg::Z_QUARTER) begin
      zb_in = pitch_s - mlo_pkg::Z_HALF;
      negb_in = 1'b1;
    end else if (pitch_s < mlo_pkg::Z_QUARTER_N) begin
      zb_in = pitch_s + mlo_pkg::Z_HALF;
      negb_in = 1'b1;
    end else begin
      zb_in = pitch_s;
    end
  end

  assign at = 27'(mlo_pkg::atan_q16(cmd.step));
  assign xas = xa_r >>> cmd.step;
  assign yas = ya_r >>> cmd.step;
  assign xbs = xb_r >>> cmd.step;
  assign ybs = yb_r >>> cmd.step;

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      first_r <= 1'b1;
      prev_x_r <= '0;
      prev_y_r <= '0;
      pitch_r <= '0;
      yaw_r <= '0;
    end else begin
      if (cmd.load) begin
        if (in_mode) begin
          en_r <= !en_r;
          if (!en_r) begin
            first_r <= 1'b1;
          end
        end else if (en_r) begin
          prev_x_r <= in_cursor_x;
          prev_y_r <= in_cursor_y;
          first_r <= 1'b0;
        end
      end
      if (cmd.pitch_we) begin
        pitch_r <= pitch_cl[23:0];
      end
      if (cmd.mod_last) begin
        yaw_r <= {rem_w[5:0], mod_r[18:0]};
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= {in_cursor_x[15], in_cursor_x} - {base_x[15], base_x};
      dy_r <= {in_cursor_y[15], in_cursor_y} - {base_y[15], base_y};
    end
    if (cmd.mul_en) begin
      prod_r <= ma * mb;
    end
    if (cmd.mod_init) begin
      mod_r <= mod_sum[34:0];
    end
    if (cmd.mod_step) begin
      quo_r <= quo_mul[30:21];
    end
    if (cmd.prep) begin
      xa_r <= mlo_pkg::CORDIC_GAIN;
      ya_r <= '0;
      za_r <= za_in;
      nega_r <= nega_in;
      xb_r <= mlo_pkg::CORDIC_GAIN;
      yb_r <= '0;
      zb_r <= zb_in;
      negb_r <= negb_in;
    end else if (cmd.rot) begin
      if (!za_r[26]) begin
        xa_r <= xa_r - yas;
        ya_r <= ya_r + xas;
        za_r <= za_r - at;
      end else begin
        xa_r <= xa_r + yas;
        ya_r <= ya_r - xas;
        za_r <= za_r + at;
      end
      if (!zb_r[26]) begin
        xb_r <= xb_r - ybs;
        yb_r <= yb_r + xbs;
        zb_r <= zb_r - at;
      end else begin
        xb_r <= xb_r + ybs;
        yb_r <= yb_r - xbs;
        zb_r <= zb_r + at;
      end
    end
    if (cmd.cap_y) begin
      ry_r <= mlo_pkg::rnd_sat15(spitch);
    end
    if (cmd.cap_x) begin
      rx_r <= mlo_pkg::rnd_sat45(prod_r);
    end
    if (cmd.cap_z) begin
      rz_r <= mlo_pkg::rnd_sat45(prod_r);
    end
  end

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r <= mlo_pkg::PITCH_MAX24) && (pitch_r >= mlo_pkg::PITCH_MIN24))
    else $error("pitch outside clamp range");

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    yaw_r < mlo_pkg::YAW_FULL_U)
    else $error("yaw not reduced below full turn");

  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && in_mode |=> en_r != $past(en_r))
    else $error("toggle item did not flip enable");

  a_sample_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && !in_mode && en_r |=> !first_r && en_r)
    else $error("enabled sample left first-sample flag set");

endmodule
`default_nettype wire

### hdl/mouse_look_orientation_core.sv
// mouse-look orientation top level: config register, controller, datapath, output register
//
// Input items arrive on in_valid / in_stall with in_mode, in_cursor_x, in_cursor_y.
// in_mode 0 is a cursor sample, in_mode 1 toggles mouse look on or off. Every item
// gives exactly one result item on out_valid / out_stall: the unit look vector
// dir_x, dir_y, dir_z in Q1.15 and the controls_on flag after the item.
// An enabled sample passes these steps in order: the shared multiplier for the angle
// steps, the yaw remainder, the fold into the cordic range, sixteen cordic iterations
// (yaw and pitch side by side), the two products, the rounding of dir_z, the hand-off
// and the return to idle.
// A toggle or a sample while disabled skips the angle update.
// The block holds off new items (in_stall high) while one item is in work.
// The result sits in an output register; the next item is accepted while it waits.
// If the receiver still stalls when the next result is ready, the block waits.
// Sensitivity is written through the APB port at address 0 (reset 6554).
// After reset: angles zero, controls on, the next sample gives zero delta.
`default_nettype none
module mouse_look_orientation_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [15:0] in_cursor_x,
  input  wire logic signed [15:0] in_cursor_y,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_dir_x,
  output logic signed [15:0]      out_dir_y,
  output logic signed [15:0]      out_dir_z,
  output logic                    out_controls_on,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [15:0]         sens_r;
  logic                out_valid_r;
  logic signed [15:0]  dir_x_r, dir_y_r, dir_z_r;
  logic                on_r;
  logic                out_free;
  logic                busy;
  mlo_pkg::mlo_cmd_t   cmd;
  mlo_pkg::mlo_stat_t  stat;
  logic signed [15:0]  res_x, res_y, res_z;
  logic                res_on;

  assign pready = 1'b1;
  assign prdata = (paddr == mlo_pkg::REG_SENS) ? {16'b0, sens_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= mlo_pkg::SENS_RESET;
    end else if (psel && penable && pwrite && paddr == mlo_pkg::REG_SENS) begin
      sens_r <= pwdata[15:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy;

  mlo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  mlo_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_mode     (in_mode),
    .in_cursor_x (in_cursor_x),
    .in_cursor_y (in_cursor_y),
    .sens        (sens_r),
    .stat        (stat),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_z       (res_z),
    .res_on      (res_on)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      dir_x_r <= res_x;
      dir_y_r <= res_y;
      dir_z_r <= res_z;
      on_r <= res_on;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dir_x = dir_x_r;
  assign out_dir_y = dir_y_r;
  assign out_dir_z = dir_z_r;
  assign out_controls_on = on_r;

endmodule
`default_nettype wire
